/* src/ipv4hp_pkg.sv */
// ----------------------------------------------------------------------------
// ipv4hp_pkg
// Shared types, character codes and octet helpers for the host:port parser.
// ----------------------------------------------------------------------------
package ipv4hp_pkg;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [8:0]  OCTET_MAX = 9'd255;
  localparam logic [8:0]  OCTET_SAT = 9'd256;
  localparam logic [2:0]  COUNT_SAT = 3'd5;
  localparam logic [2:0]  COUNT_FULL = 3'd4;
  localparam logic [31:0] ADDR_ERR  = 32'hFFFF_FFFF;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADCHAR = 2'd1,
    ST_RANGE   = 2'd2,
    ST_COUNT   = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] address_acc;
    logic [8:0]  octet_acc;
    logic [2:0]  octet_count;
    status_t     error_code;
    logic        after_colon;
    logic [15:0] port_acc;
    logic        junk_seen;
  } parse_state_t;

  typedef struct packed {
    logic        port_had_junk;
    status_t     status;
    logic [15:0] port_number;
    logic [31:0] address;
  } result_t;

  localparam parse_state_t STATE_RESET = '{
    address_acc: 32'd0,
    octet_acc:   9'd0,
    octet_count: 3'd0,
    error_code:  ST_OK,
    after_colon: 1'b0,
    port_acc:    16'd0,
    junk_seen:   1'b0
  };

  function automatic parse_state_t set_error(parse_state_t s, status_t code);
    parse_state_t r;
    r = s;
    if (s.error_code == ST_OK) begin
      r.error_code = code;
    end
    return r;
  endfunction

  function automatic parse_state_t end_octet(parse_state_t s);
    parse_state_t r;
    r = s;
    if (s.octet_acc > OCTET_MAX) begin
      r = set_error(r, ST_RANGE);
    end else if (s.octet_count < COUNT_FULL) begin
      r.address_acc[{s.octet_count[1:0], 3'b000} +: 8] =
        s.address_acc[{s.octet_count[1:0], 3'b000} +: 8] | s.octet_acc[7:0];
    end
    if (s.octet_count < COUNT_SAT) begin
      r.octet_count = s.octet_count + 3'd1;
    end
    r.octet_acc = 9'd0;
    return r;
  endfunction

endpackage

/* src/ipv4hp_in_stage.sv */
// ----------------------------------------------------------------------------
// ipv4hp_in_stage
// Input register: holds one character beat for the parser core.
// ----------------------------------------------------------------------------
module ipv4hp_in_stage
  import ipv4hp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] character
  input  logic       in_tlast,   // last_char
  output logic       s1_valid,
  input  logic       s1_ready,
  output logic [7:0] s1_char,
  output logic       s1_last
);

  logic       valid_r;
  logic [7:0] char_r;
  logic       last_r;

  assign in_tready = !valid_r || s1_ready;
  assign s1_valid  = valid_r;
  assign s1_char   = char_r;
  assign s1_last   = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      char_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

endmodule

/* src/ipv4hp_core.sv */
// ----------------------------------------------------------------------------
// ipv4hp_core
// Parse state and per-character update; emits a result on the last beat.
// ----------------------------------------------------------------------------
module ipv4hp_core
  import ipv4hp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       s1_valid,
  output logic       s1_ready,
  input  logic [7:0] s1_char,
  input  logic       s1_last,
  output logic       res_valid,
  input  logic       res_ready,
  output result_t    res
);

  parse_state_t st_r;
  parse_state_t st_step;
  parse_state_t st_fin;
  parse_state_t st_nxt;
  logic         digit;
  logic [3:0]   dval;
  logic [11:0]  oct_v;
  logic [15:0]  port_v;
  logic         fire;

  assign s1_ready  = !s1_last || res_ready;
  assign fire      = s1_valid && s1_ready;
  assign res_valid = s1_valid && s1_last && res_ready;

  always_comb begin
    digit  = (s1_char >= CH_ZERO) && (s1_char <= CH_NINE);
    dval   = digit ? s1_char[3:0] : 4'd0;
    oct_v  = {3'b000, st_r.octet_acc} * 12'd10 + {8'd0, dval};
    port_v = st_r.port_acc * 16'd10 + {12'd0, dval};

    st_step = st_r;
    if (st_r.after_colon) begin
      if (digit) begin
        st_step.port_acc = port_v;
      end else begin
        st_step.junk_seen = 1'b1;
      end
    end else if (s1_char == CH_DOT) begin
      st_step = end_octet(st_r);
    end else if (digit) begin
      st_step.octet_acc = (oct_v > {3'b000, OCTET_SAT}) ? OCTET_SAT : oct_v[8:0];
    end else if (s1_char == CH_COLON) begin
      st_step = end_octet(st_r);
      st_step.after_colon = 1'b1;
    end else begin
      st_step = set_error(st_r, ST_BADCHAR);
    end

    st_fin = st_step;
    if (!st_step.after_colon) begin
      st_fin = end_octet(st_step);
    end
    if (st_fin.octet_count != COUNT_FULL) begin
      st_fin = set_error(st_fin, ST_COUNT);
    end

    res.address       = (st_fin.error_code != ST_OK) ? ADDR_ERR : st_fin.address_acc;
    res.port_number   = st_fin.after_colon ? st_fin.port_acc : 16'd0;
    res.status        = st_fin.error_code;
    res.port_had_junk = st_fin.junk_seen;

    st_nxt = st_r;
    if (fire) begin
      st_nxt = s1_last ? STATE_RESET : st_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

/* src/ipv4hp_out_stage.sv */
// ----------------------------------------------------------------------------
// ipv4hp_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module ipv4hp_out_stage
  import ipv4hp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_valid,
  output logic                   res_ready,
  input  result_t                res,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic    valid_r;
  result_t res_r;

  assign res_ready  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

endmodule

/* src/ipv4_host_port_parser.sv */
// ----------------------------------------------------------------------------
// ipv4_host_port_parser
// Parses "a.b.c.d:port" one character per beat into address, port, status.
//
//   channel | dir | tdata                                   | tlast
//   in_     | in  | [7:0] character                         | last_char
//   out_    | out | [31:0] address, [47:32] port_number,    | -
//           |     | [49:48] status, [50] port_had_junk      |
//
// One character per cycle unless a last character waits on the output; results
// are held in the result register. Input register, parse update and result register
// form a two-stage pipeline. Synchronous active-low reset clears the parse
// state and both valid flags. A stalled output only blocks last characters;
// other characters keep flowing.
// ----------------------------------------------------------------------------
module ipv4_host_port_parser
  import ipv4hp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] character
  input  logic                   in_tlast,   // last_char
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // address, port_number, status, port_had_junk, pad
);

  logic       s1_valid;
  logic       s1_ready;
  logic [7:0] s1_char;
  logic       s1_last;
  logic       res_valid;
  logic       res_ready;
  result_t    res;

  ipv4hp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_char   (s1_char),
    .s1_last   (s1_last)
  );

  ipv4hp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_char   (s1_char),
    .s1_last   (s1_last),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ipv4hp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ipv4_host_port_parser. Host:port strings go in
// one character per beat; a local parser tracks octets, dots, colon and
// port for each accepted beat and queues the endpoint it expects on the
// last character. Each result beat is compared field by field. Directed
// strings cover the extremes and error cases, then random well-formed,
// damaged and noise strings follow, with random stalls on both sides and
// a stretch without any stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ipv4hp_pkg::*;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [7:0] character
  logic                   in_tlast = 1'b0; // last_char
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [31:0] address, [47:32] port_number,
                                           // [49:48] status, [50] port_had_junk

  int unsigned idle_pct = 30;
  int unsigned beats_sent = 0;
  int unsigned mismatch_count = 0;

  result_t     expected_endpoints[$];
  result_t     next_endpoint;
  logic [7:0]  line_buf[$];

  logic [31:0] addr_bytes;
  logic [8:0]  octet_val;
  logic [2:0]  octets_done;
  status_t     first_error;
  logic        seen_colon;
  logic [15:0] port_val;
  logic        port_junk;

  ipv4_host_port_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void clear_parse();
    addr_bytes  = '0;
    octet_val   = '0;
    octets_done = '0;
    first_error = ST_OK;
    seen_colon  = 1'b0;
    port_val    = '0;
    port_junk   = 1'b0;
  endfunction

  function automatic void note_error(status_t code);
    if (first_error == ST_OK) begin
      first_error = code;
    end
  endfunction

  function automatic void close_octet();
    if (octet_val > OCTET_MAX) begin
      note_error(ST_RANGE);
    end else if (octets_done < COUNT_FULL) begin
      addr_bytes = addr_bytes | (32'(octet_val[7:0]) << (8 * octets_done));
    end
    if (octets_done < COUNT_SAT) begin
      octets_done = octets_done + 3'd1;
    end
    octet_val = '0;
  endfunction

  function automatic void parse_char(logic [7:0] ch, logic last);
    logic        is_digit;
    logic [3:0]  d;
    int unsigned acc;
    result_t     res;
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    d = is_digit ? 4'(ch - CH_ZERO) : 4'd0;
    if (seen_colon) begin
      if (is_digit) begin
        port_val = 16'(port_val * 10 + d);
      end else begin
        port_junk = 1'b1;
      end
    end else if (ch == CH_DOT) begin
      close_octet();
    end else if (is_digit) begin
      acc = octet_val * 10 + d;
      octet_val = (acc > OCTET_SAT) ? OCTET_SAT : 9'(acc);
    end else if (ch == CH_COLON) begin
      close_octet();
      seen_colon = 1'b1;
    end else begin
      note_error(ST_BADCHAR);
    end
    if (last) begin
      if (!seen_colon) begin
        close_octet();
      end
      if (octets_done != COUNT_FULL) begin
        note_error(ST_COUNT);
      end
      res.address       = (first_error != ST_OK) ? ADDR_ERR : addr_bytes;
      res.port_number   = seen_colon ? port_val : 16'd0;
      res.status        = first_error;
      res.port_had_junk = port_junk;
      expected_endpoints.push_back(res);
      clear_parse();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 100) begin
      $display("ERROR @%0t: %s got %0h expected %0h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_endpoints.size() == 0) begin
        report_mismatch("unexpected result, address", out_tdata[31:0], '0);
      end else begin
        next_endpoint = expected_endpoints.pop_front();
        if (out_tdata[31:0] !== next_endpoint.address)
          report_mismatch("address", out_tdata[31:0], next_endpoint.address);
        if (out_tdata[47:32] !== next_endpoint.port_number)
          report_mismatch("port_number", 32'(out_tdata[47:32]),
                          32'(next_endpoint.port_number));
        if (out_tdata[49:48] !== next_endpoint.status)
          report_mismatch("status", 32'(out_tdata[49:48]), 32'(next_endpoint.status));
        if (out_tdata[50] !== next_endpoint.port_had_junk)
          report_mismatch("port_had_junk", 32'(out_tdata[50]),
                          32'(next_endpoint.port_had_junk));
        if (out_tdata[55:51] !== '0)
          report_mismatch("pad", 32'(out_tdata[55:51]), '0);
      end
    end
  end

  task automatic send_char(input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = ch;
    in_tlast  = last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_char(ch, last);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) begin
      send_char(line_buf[i], i == line_buf.size() - 1);
    end
    line_buf.delete();
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      line_buf.push_back(s[i]);
    end
  endfunction

  task automatic send_text(input string s);
    push_text(s);
    send_line();
  endtask

  function automatic logic [7:0] rand_bad_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT || b == CH_COLON);
    return b;
  endfunction

  function automatic void push_octet();
    int unsigned mode;
    mode = $urandom_range(19);
    case (mode)
      0: begin
      end
      1: push_text($sformatf("%0d", $urandom_range(999, 256)));
      2: begin
        repeat ($urandom_range(8, 4)) line_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
      3: begin
        repeat ($urandom_range(3, 1)) line_buf.push_back(CH_ZERO);
        push_text($sformatf("%0d", $urandom_range(255)));
      end
      4: push_text("0");
      5: push_text("255");
      default: push_text($sformatf("%0d", $urandom_range(255)));
    endcase
  endfunction

  function automatic void build_host_line();
    int unsigned n_octets;
    int unsigned addr_len;
    n_octets = ($urandom_range(9) == 0) ? $urandom_range(6) : 4;
    for (int i = 0; i < n_octets; i++) begin
      if (i > 0) begin
        line_buf.push_back(CH_DOT);
      end
      push_octet();
    end
    addr_len = line_buf.size();
    if ($urandom_range(7) == 0) begin
      line_buf.insert($urandom_range(addr_len), rand_bad_byte());
    end
    if ($urandom_range(4) != 0) begin
      line_buf.push_back(CH_COLON);
      repeat ($urandom_range(7)) line_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
      if ($urandom_range(5) == 0) begin
        line_buf.insert($urandom_range(line_buf.size(), addr_len + 1),
                        ($urandom_range(1) == 0) ? CH_COLON : 8'($urandom_range(255)));
      end
    end
    if (line_buf.size() == 0) begin
      line_buf.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic test_address_extremes();
    send_text("0.0.0.0:0");
    send_text("255.255.255.255:65535");
    send_text("1.2.3.4");
  endtask

  task automatic test_octet_range();
    send_text("256.1.1.1:8");
    send_text("1.2.3.99999");
  endtask

  task automatic test_octet_count();
    send_text("1.2.3:7");
    send_text("1.2.3.4.5.6:9");
    send_text("...");
  endtask

  task automatic test_bad_chars();
    send_text("9x.999.1.1");
    line_buf.push_back(8'h00);
    send_line();
    push_text("1.2.3.4");
    line_buf.push_back(8'hFF);
    send_line();
  endtask

  task automatic test_port_forms();
    send_text("1.2.3.4:");
    send_text("5.6.7.8:1:2");
    send_text("1.2.3.4:99999");
    send_text("1.2.3.4:8a");
  endtask

  task automatic run_random_lines(input int unsigned beat_target);
    while (beats_sent < beat_target) begin
      if ($urandom_range(99) < 85) begin
        build_host_line();
      end else begin
        repeat ($urandom_range(6, 1)) line_buf.push_back(8'($urandom_range(255)));
      end
      send_line();
    end
  endtask

  task automatic test_back_to_back();
    idle_pct = 0;
    run_random_lines(beats_sent + 250);
    idle_pct = 30;
  endtask

  task automatic test_random_lines();
    run_random_lines(1700);
  endtask

  initial begin
    clear_parse();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_address_extremes();
    test_octet_range();
    test_octet_count();
    test_bad_chars();
    test_port_forms();
    test_back_to_back();
    test_random_lines();

    in_tvalid = 1'b0;
    in_tlast  = 1'b0;
    while (expected_endpoints.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
